### sv/bafl_pkg.sv
`timescale 1ns / 1ps
// bafl_pkg: shared constants, widths and tables for the amplitude-from-lift block.
// No dependencies.
`default_nettype none

package bafl_pkg;

   // Parameter defaults
   localparam int POSITION_BITS_DEF   = 32;
   localparam int CORDIC_STAGES_DEF   = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 8;

   // Register widths and reset values
   localparam int SR_W   = 18;
   localparam int BPH_W  = 17;
   localparam int LIFT_W = 15;
   localparam int CSR_W  = 18;
   localparam int IDX_W  = 2;
   localparam logic [SR_W-1:0]   SAMPLE_RATE_RST    = 18'd48000;
   localparam logic [BPH_W-1:0]  BEATS_PER_HOUR_RST = 17'd28800;
   localparam logic [LIFT_W-1:0] LIFT_ANGLE_RST     = 15'd13312;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_SAMPLE_RATE    = 2'd0;
   localparam logic [IDX_W-1:0] REG_BEATS_PER_HOUR = 2'd1;
   localparam logic [IDX_W-1:0] REG_LIFT_ANGLE     = 2'd2;

   // Status codes
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DEGEN = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   localparam int AMP_W = 17;

   // Turn denominator: 7200 * sample rate fits 31 bits
   localparam int DEN_W = 31;
   localparam logic [DEN_W-1:0] BEAT_DIV = 31'd7200;

   // Phase: 32-bit fraction of a turn
   localparam int PHASE_W = 32;

   // CORDIC datapath, x/y in Q30, angle in 2^-32 turn
   localparam int CW = 34;
   localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [CW-1:0] TURN_HALF       = 34'sd2147483648;
   localparam logic signed [CW-1:0] TURN_QUARTER    = 34'sd1073741824;
   localparam int ATAN_W = 30;
   localparam int ATAN_N = 24;
   localparam logic [ATAN_W-1:0] ATAN_TURN [0:ATAN_N-1] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10680862, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41721, 30'd20860,
      30'd10430, 30'd5215, 30'd2607, 30'd1303, 30'd651, 30'd325, 30'd162, 30'd81
   };

   // Amplitude quotient: 360 degrees needs 9 integer bits
   localparam int DEG_BITS = 9;
   localparam int DEG_FULL = 360;

endpackage

`default_nettype wire

### sv/bafl_div.sv
`timescale 1ns / 1ps
// bafl_div: pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; numerator must be below den << QB.
`default_nettype none

module bafl_div #(
   parameter int DW = 31,
   parameter int QB = 16,
   parameter int PW = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [DW+QB-1:0] in_num,
   input  wire logic [DW-1:0]    in_den,
   input  wire logic [PW-1:0]    in_pay,
   output logic                  out_valid,
   output logic [DW-1:0]         out_rem,
   output logic [QB-1:0]         out_quo,
   output logic [PW-1:0]         out_pay
);

   localparam int W = DW + QB;

   logic          v_ff   [QB];
   logic [W-1:0]  rem_ff [QB];
   logic [DW-1:0] den_ff [QB];
   logic [QB-1:0] quo_ff [QB];
   logic [PW-1:0] pay_ff [QB];

   for (genvar s = 0; s < QB; s++) begin : g_stage
      localparam int J = QB - 1 - s;
      logic          v_cur;
      logic [W-1:0]  rem_cur;
      logic [DW-1:0] den_cur;
      logic [QB-1:0] quo_cur;
      logic [PW-1:0] pay_cur;
      logic [W-1:0]  trial;
      logic          take;
      logic [W-1:0]  rem_in;
      logic [QB-1:0] quo_in;

      if (s == 0) begin : g_first
         assign v_cur   = in_valid;
         assign rem_cur = in_num;
         assign den_cur = in_den;
         assign quo_cur = '0;
         assign pay_cur = in_pay;
      end else begin : g_next
         assign v_cur   = v_ff[s-1];
         assign rem_cur = rem_ff[s-1];
         assign den_cur = den_ff[s-1];
         assign quo_cur = quo_ff[s-1];
         assign pay_cur = pay_ff[s-1];
      end

      assign trial = W'(den_cur) << J;
      assign take  = rem_cur >= trial;

      always_comb begin
         rem_in    = take ? rem_cur - trial : rem_cur;
         quo_in    = quo_cur;
         quo_in[J] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_cur;
         end
         if (en) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_cur;
            quo_ff[s] <= quo_in;
            pay_ff[s] <= pay_cur;
         end
      end
   end

   assign out_valid = v_ff[QB-1];
   assign out_rem   = rem_ff[QB-1][DW-1:0];
   assign out_quo   = quo_ff[QB-1];
   assign out_pay   = pay_ff[QB-1];

endmodule

`default_nettype wire

### sv/bafl_cordic.sv
`timescale 1ns / 1ps
// bafl_cordic: rotation-mode CORDIC sine, one micro-rotation per register stage.
// Depends on bafl_pkg (gain, arctangent table, datapath width).
`default_nettype none

module bafl_cordic #(
   parameter int STAGES = 16,
   parameter int PW     = 1
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  wire logic                            in_valid,
   input  wire logic signed [bafl_pkg::CW-1:0]  in_theta,
   input  wire logic [PW-1:0]                   in_pay,
   output logic                                 out_valid,
   output logic signed [bafl_pkg::CW-1:0]       out_sine,
   output logic [PW-1:0]                        out_pay
);

   logic                           v_ff   [STAGES];
   logic signed [bafl_pkg::CW-1:0] x_ff   [STAGES];
   logic signed [bafl_pkg::CW-1:0] y_ff   [STAGES];
   logic signed [bafl_pkg::CW-1:0] z_ff   [STAGES];
   logic [PW-1:0]                  pay_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic                           v_cur;
      logic signed [bafl_pkg::CW-1:0] x_cur, y_cur, z_cur;
      logic [PW-1:0]                  pay_cur;
      logic signed [bafl_pkg::CW-1:0] dx, dy, at;
      logic signed [bafl_pkg::CW-1:0] x_in, y_in, z_in;

      if (i == 0) begin : g_first
         assign v_cur   = in_valid;
         assign x_cur   = bafl_pkg::CORDIC_GAIN_Q30;
         assign y_cur   = '0;
         assign z_cur   = in_theta;
         assign pay_cur = in_pay;
      end else begin : g_next
         assign v_cur   = v_ff[i-1];
         assign x_cur   = x_ff[i-1];
         assign y_cur   = y_ff[i-1];
         assign z_cur   = z_ff[i-1];
         assign pay_cur = pay_ff[i-1];
      end

      assign dx = y_cur >>> i;
      assign dy = x_cur >>> i;
      assign at = signed'(bafl_pkg::CW'(bafl_pkg::ATAN_TURN[i]));

      always_comb begin
         if (!z_cur[bafl_pkg::CW-1]) begin
            x_in = x_cur - dx;
            y_in = y_cur + dy;
            z_in = z_cur - at;
         end else begin
            x_in = x_cur + dx;
            y_in = y_cur - dy;
            z_in = z_cur + at;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_cur;
         end
         if (en) begin
            x_ff[i]   <= x_in;
            y_ff[i]   <= y_in;
            z_ff[i]   <= z_in;
            pay_ff[i] <= pay_cur;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_sine  = y_ff[STAGES-1];
   assign out_pay   = pay_ff[STAGES-1];

endmodule

`default_nettype wire

### sv/balance_amplitude_from_lift_top.sv
`timescale 1ns / 1ps
// balance_amplitude_from_lift_top: balance amplitude from A/C sound positions.
// Depends on bafl_pkg, bafl_div and bafl_cordic.
//
// Usage:
//   req_ channel carries one word per tick: A and C sample positions.
//   rsp_ channel returns one word per request: amplitude (degrees, Q.8)
//   and status (ok, sine degenerate, out of range).
//   csr_ channel writes sample_rate (0), beats_per_hour (1), lift_angle (2);
//   csr_ready is always high. Write only while the pipeline is empty.
// Pipeline: entry reg, POSITION_BITS mod stages, fixup, multiply,
//   17 mod stages, 32 phase-division stages, fold, CORDIC_STAGES rotations,
//   classify, 9+ANGLE_FRAC_BITS amplitude-division stages, output reg.
//   One word accepted per cycle while the output is not stalled, bound by
//   the one-bit-per-stage dividers being fully pipelined.
// Reset: clears all valid bits and loads the register defaults
//   (48000 Hz, 28800 bph, 52.0 degrees lift).
// Stall: when rsp_valid is high and rsp_ready low, the whole pipeline
//   holds and req_ready drops; nothing is lost or repeated.
`default_nettype none

module balance_amplitude_from_lift_top #(
   parameter int POSITION_BITS   = bafl_pkg::POSITION_BITS_DEF,
   parameter int CORDIC_STAGES   = bafl_pkg::CORDIC_STAGES_DEF,
   parameter int ANGLE_FRAC_BITS = bafl_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request words
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [POSITION_BITS-1:0]      req_a_pos,
   input  wire logic [POSITION_BITS-1:0]      req_c_pos,
   // result words
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [bafl_pkg::AMP_W-1:0]         rsp_amplitude,
   output logic [bafl_pkg::STATUS_W-1:0]      rsp_status,
   // register writes
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [bafl_pkg::IDX_W-1:0]    csr_index,
   input  wire logic [bafl_pkg::CSR_W-1:0]    csr_data
);

   localparam int DW   = bafl_pkg::DEN_W;
   localparam int CW   = bafl_pkg::CW;
   localparam int SW   = bafl_pkg::STATUS_W;
   localparam int QB4  = bafl_pkg::DEG_BITS + ANGLE_FRAC_BITS;  // amplitude quotient bits
   localparam int W4   = DW + QB4;
   localparam int NW4  = 64;
   localparam logic [QB4-1:0] LIMIT = QB4'(bafl_pkg::DEG_FULL << ANGLE_FRAC_BITS);

   // global advance: whole pipeline moves unless the output word is stuck
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   // ---------------- configuration ----------------
   logic [bafl_pkg::SR_W-1:0]   sample_rate_ff;
   logic [bafl_pkg::BPH_W-1:0]  bph_ff;
   logic [bafl_pkg::LIFT_W-1:0] lift_ff;
   logic [DW-1:0]               den_ff, den_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= bafl_pkg::SAMPLE_RATE_RST;
         bph_ff         <= bafl_pkg::BEATS_PER_HOUR_RST;
         lift_ff        <= bafl_pkg::LIFT_ANGLE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            bafl_pkg::REG_SAMPLE_RATE:    sample_rate_ff <= csr_data[bafl_pkg::SR_W-1:0];
            bafl_pkg::REG_BEATS_PER_HOUR: bph_ff         <= csr_data[bafl_pkg::BPH_W-1:0];
            bafl_pkg::REG_LIFT_ANGLE:     lift_ff        <= csr_data[bafl_pkg::LIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // samples per turn-of-beat: 7200 * fs, zero rate treated as one
   always_comb begin
      den_in = bafl_pkg::BEAT_DIV;
      if (sample_rate_ff != '0) begin
         den_in = DW'(DW'(sample_rate_ff) * bafl_pkg::BEAT_DIV);
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
   end

   // ---------------- entry: |c - a| and direction ----------------
   logic                     v0_ff;
   logic [POSITION_BITS-1:0] mag_ff;
   logic                     back_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
      if (en) begin
         back_ff <= req_c_pos < req_a_pos;
         mag_ff  <= (req_c_pos < req_a_pos) ? req_a_pos - req_c_pos
                                            : req_c_pos - req_a_pos;
      end
   end

   // ---------------- |diff| mod den ----------------
   logic          v1;
   logic [DW-1:0] rem1;
   logic          back1;

   bafl_div #(.DW(DW), .QB(POSITION_BITS), .PW(1)) u_mod_diff (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v0_ff),
      .in_num   ({{DW{1'b0}}, mag_ff}),
      .in_den   (den_ff),
      .in_pay   (back_ff),
      .out_valid(v1),
      .out_rem  (rem1),
      .out_quo  (),
      .out_pay  (back1)
   );

   // backward difference folds into the turn: den - t unless t is zero
   logic          v2_ff;
   logic [DW-1:0] dm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1;
      end
      if (en) begin
         dm_ff <= (back1 && rem1 != '0) ? den_ff - rem1 : rem1;
      end
   end

   // ---------------- times beats per hour ----------------
   localparam int PRW = DW + bafl_pkg::BPH_W;
   logic           v3_ff;
   logic [PRW-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         prod_ff <= PRW'(dm_ff) * PRW'(bph_ff);
      end
   end

   // product < den << 17, so 17 quotient bits reach the remainder
   logic          v4;
   logic [DW-1:0] r4;

   bafl_div #(.DW(DW), .QB(bafl_pkg::BPH_W), .PW(1)) u_mod_beat (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v3_ff),
      .in_num   (prod_ff),
      .in_den   (den_ff),
      .in_pay   (1'b0),
      .out_valid(v4),
      .out_rem  (r4),
      .out_quo  (),
      .out_pay  ()
   );

   // ---------------- phase = floor(r * 2^32 / den) ----------------
   logic                            v5;
   logic [bafl_pkg::PHASE_W-1:0]    phase5;

   bafl_div #(.DW(DW), .QB(bafl_pkg::PHASE_W), .PW(1)) u_phase (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v4),
      .in_num   ({r4, {bafl_pkg::PHASE_W{1'b0}}}),
      .in_den   (den_ff),
      .in_pay   (1'b0),
      .out_valid(v5),
      .out_rem  (),
      .out_quo  (phase5),
      .out_pay  ()
   );

   // ---------------- fold phase into [-1/4, 1/4] turn ----------------
   logic                 v6_ff;
   logic signed [CW-1:0] th_ff, th_in, sp;
   logic                 degen6_ff;

   always_comb begin
      sp = signed'(CW'(signed'({phase5[bafl_pkg::PHASE_W-1], phase5})));
      if (sp > bafl_pkg::TURN_QUARTER) begin
         th_in = bafl_pkg::TURN_HALF - sp;
      end else if (sp < -bafl_pkg::TURN_QUARTER) begin
         th_in = -bafl_pkg::TURN_HALF - sp;
      end else begin
         th_in = sp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5;
      end
      if (en) begin
         th_ff     <= th_in;
         degen6_ff <= th_in == '0;
      end
   end

   // ---------------- sine ----------------
   logic                 v7;
   logic signed [CW-1:0] y7;
   logic                 degen7;

   bafl_cordic #(.STAGES(CORDIC_STAGES), .PW(1)) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v6_ff),
      .in_theta (th_ff),
      .in_pay   (degen6_ff),
      .out_valid(v7),
      .out_sine (y7),
      .out_pay  (degen7)
   );

   // ---------------- classify, build amplitude dividend ----------------
   logic           v8_ff;
   logic [W4-1:0]  num8_ff;
   logic [DW-1:0]  ysin8_ff;
   logic [SW-1:0]  st8_ff;
   logic [DW-1:0]  ypos;
   logic [NW4-1:0] num_wide, lim_wide;
   logic [SW-1:0]  st_in;

   always_comb begin
      ypos     = y7[DW-1:0];
      num_wide = (NW4'(lift_ff) << 30) + NW4'(ypos >> 1);
      lim_wide = NW4'(ypos) << QB4;
      if (degen7 || y7 == '0) begin
         st_in = bafl_pkg::ST_DEGEN;
      end else if (y7[CW-1] || num_wide >= lim_wide) begin
         // negative sine, or quotient would not fit its QB4 bits (512 degrees or more)
         st_in = bafl_pkg::ST_RANGE;
      end else begin
         st_in = bafl_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (en) begin
         v8_ff <= v7;
      end
      if (en) begin
         st8_ff   <= st_in;
         num8_ff  <= (st_in == bafl_pkg::ST_OK) ? num_wide[W4-1:0] : '0;
         ysin8_ff <= (st_in == bafl_pkg::ST_OK) ? ypos : DW'(1);
      end
   end

   // ---------------- amplitude = (lift * 2^30 + y/2) / y ----------------
   logic           v9;
   logic [QB4-1:0] q9;
   logic [SW-1:0]  st9;

   bafl_div #(.DW(DW), .QB(QB4), .PW(SW)) u_amp (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v8_ff),
      .in_num   (num8_ff),
      .in_den   (ysin8_ff),
      .in_pay   (st8_ff),
      .out_valid(v9),
      .out_rem  (),
      .out_quo  (q9),
      .out_pay  (st9)
   );

   // ---------------- output register ----------------
   logic                      rsp_valid_ff;
   logic [bafl_pkg::AMP_W-1:0] amp_ff, amp_in;
   logic [SW-1:0]             status_ff, status_in;

   always_comb begin
      amp_in    = '0;
      status_in = st9;
      if (st9 == bafl_pkg::ST_OK) begin
         if (q9 == '0 || q9 >= LIMIT) begin
            status_in = bafl_pkg::ST_RANGE;
         end else begin
            amp_in = bafl_pkg::AMP_W'(q9);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v9;
      end
      if (en) begin
         amp_ff    <= amp_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_amplitude = amp_ff;
   assign rsp_status    = status_ff;

endmodule

`default_nettype wire
